/* src/sap_pkg.sv */
package sap_pkg;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_MOVE = 2'd1;
	localparam logic [1:0] FUNC_ZERO = 2'd2;

	localparam int DEG_W    = 13;
	localparam int POS_W    = 16;
	localparam int COIL_W   = 4;
	localparam int DEG_MAG  = 4096;
	localparam int DEG_REV  = 360;

	// item leaving the angle conversion pipeline
	typedef struct packed {
		logic                    valid;
		logic [1:0]              func;
		logic signed [DEG_W-1:0] deg;
		logic                    neg;
	} item_t;

	// bits of |angle| * steps per revolution
	function automatic int prod_width(input int spr);
		return $clog2(DEG_MAG * spr + 1);
	endfunction

	// bits of the step target magnitude after the divide by 360
	function automatic int quot_width(input int spr);
		return prod_width(spr) - 8;
	endfunction

	function automatic logic [COIL_W-1:0] coil_pattern(input logic [1:0] phase);
		logic [COIL_W-1:0] pat;
		unique case (phase)
			2'd0: pat = 4'h3;
			2'd1: pat = 4'h6;
			2'd2: pat = 4'hC;
			2'd3: pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

/* src/sap_if.sv */
interface sap_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [12:0] target_deg;
	logic signed [12:0] min_deg;
	logic signed [12:0] max_deg;

	modport source (output valid, output func, output target_deg, output min_deg,
		output max_deg, input ready);
	modport sink (input valid, input func, input target_deg, input min_deg,
		input max_deg, output ready);
endinterface

interface sap_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         coils;
	logic               coils_driven;
	logic               busy_res;
	logic signed [15:0] step_pos;
	logic signed [12:0] shown_deg;
	logic               arrived;

	modport source (output valid, output coils, output coils_driven, output busy_res,
		output step_pos, output shown_deg, output arrived, input ready);
	modport sink (input valid, input coils, input coils_driven, input busy_res,
		input step_pos, input shown_deg, input arrived, output ready);
endinterface

/* src/sap_conv.sv */
module sap_conv #(
	parameter int STEPS_PER_REV = 2048,
	parameter int QW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	sap_in_if.sink          cmd,
	output sap_pkg::item_t  item,
	output logic [QW-1:0]   quot,
	input  logic            item_ready
);
	import sap_pkg::*;

	localparam int NW = prod_width(STEPS_PER_REV);
	localparam int K  = NW + 9;
	localparam int MW = K - 8;
	localparam int RW = NW + MW;
	localparam longint unsigned RECIP_L = ((longint'(1) << K) + DEG_REV - 1) / DEG_REV;
	localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
	localparam logic [NW-1:0] SPR   = NW'(STEPS_PER_REV);

	// s1: input register
	logic                    v_s1;
	logic [1:0]              func_s1;
	logic signed [DEG_W-1:0] tgt_s1, lo_s1, hi_s1;
	// s2: clamped angle, sign and magnitude
	logic                    v_s2;
	logic [1:0]              func_s2;
	logic signed [DEG_W-1:0] deg_s2;
	logic                    neg_s2;
	logic [DEG_W-1:0]        mag_s2;
	// s3: magnitude times steps per revolution
	logic                    v_s3;
	logic [1:0]              func_s3;
	logic signed [DEG_W-1:0] deg_s3;
	logic                    neg_s3;
	logic [NW-1:0]           prod_s3;
	// s4: divided by 360
	logic                    v_s4;
	logic [1:0]              func_s4;
	logic signed [DEG_W-1:0] deg_s4;
	logic                    neg_s4;
	logic [QW-1:0]           quot_s4;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic signed [DEG_W-1:0] clamp_lo, clamp;
	logic [RW-1:0]           recip_prod;

	assign rdy_s4    = !v_s4 || item_ready;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign cmd.ready = rdy_s1;

	always_comb begin
		clamp_lo = (tgt_s1 < lo_s1) ? lo_s1 : tgt_s1;
		clamp    = (clamp_lo > hi_s1) ? hi_s1 : clamp_lo;
	end

	// exact floor(n / 360) for every n below 2**NW
	assign recip_prod = RW'(prod_s3) * RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= cmd.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			func_s1 <= cmd.func;
			tgt_s1  <= cmd.target_deg;
			lo_s1   <= cmd.min_deg;
			hi_s1   <= cmd.max_deg;
		end
		if (rdy_s2) begin
			func_s2 <= func_s1;
			deg_s2  <= clamp;
			neg_s2  <= clamp[DEG_W-1];
			// -(-4096) wraps to the pattern of unsigned 4096
			mag_s2  <= DEG_W'(clamp[DEG_W-1] ? -clamp : clamp);
		end
		if (rdy_s3) begin
			func_s3 <= func_s2;
			deg_s3  <= deg_s2;
			neg_s3  <= neg_s2;
			prod_s3 <= NW'(mag_s2) * SPR;
		end
		if (rdy_s4) begin
			func_s4 <= func_s3;
			deg_s4  <= deg_s3;
			neg_s4  <= neg_s3;
			quot_s4 <= recip_prod[K +: QW];
		end
	end

	assign item.valid = v_s4;
	assign item.func  = func_s4;
	assign item.deg   = deg_s4;
	assign item.neg   = neg_s4;
	assign quot       = quot_s4;

endmodule

/* src/sap_core.sv */
module sap_core #(
	parameter int QW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sap_pkg::item_t  item,
	input  logic [QW-1:0]   quot,
	output logic            item_ready,
	sap_out_if.source       rsp
);
	import sap_pkg::*;

	localparam int TW = (QW + 1 > POS_W + 1) ? QW + 1 : POS_W + 1;
	localparam logic signed [TW-1:0] POS_MAX = TW'(32767);
	localparam logic signed [TW-1:0] NEG_MIN = TW'(-32768);

	logic [COIL_W-1:0]       coil_q, coil_d;
	logic signed [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0]        left_q, left_d, left_dec;
	logic                    dir_neg_q, dir_neg_d;
	logic                    moving_q, moving_d;
	logic signed [DEG_W-1:0] goal_q, goal_d;
	logic signed [DEG_W-1:0] reached_q, reached_d;
	logic                    driven, arr;

	logic signed [TW-1:0]    ts_w;
	logic signed [POS_W-1:0] ts;
	logic signed [POS_W:0]   diff;
	logic [POS_W:0]          diff_mag;

	logic                    v_s5;
	logic [COIL_W-1:0]       coils_s5;
	logic                    driven_s5, busy_s5, arr_s5;
	logic signed [POS_W-1:0] pos_s5;
	logic signed [DEG_W-1:0] shown_s5;

	logic fire;

	assign item_ready = !v_s5 || rsp.ready;
	assign fire       = item.valid && item_ready;
	assign left_dec   = left_q - 1'b1;

	always_comb begin
		ts_w = TW'(quot);
		if (item.neg) ts_w = -ts_w;
		priority if (ts_w > POS_MAX) ts = POS_W'(POS_MAX);
		else if (ts_w < NEG_MIN)     ts = POS_W'(NEG_MIN);
		else                         ts = POS_W'(ts_w);
		diff     = (POS_W+1)'(ts) - (POS_W+1)'(pos_q);
		diff_mag = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
	end

	always_comb begin
		coil_d    = coil_q;
		pos_d     = pos_q;
		left_d    = left_q;
		dir_neg_d = dir_neg_q;
		moving_d  = moving_q;
		goal_d    = goal_q;
		reached_d = reached_q;
		driven    = 1'b0;
		arr       = 1'b0;
		unique case (item.func)
			FUNC_TICK: begin
				if (moving_q && left_q != '0) begin
					coil_d = coil_pattern(pos_q[1:0]);
					driven = 1'b1;
					left_d = left_dec;
					pos_d  = dir_neg_q ? pos_q - 1'b1 : pos_q + 1'b1;
					if (left_dec == '0) begin
						moving_d  = 1'b0;
						reached_d = goal_q;
						arr       = 1'b1;
					end
				end
			end
			FUNC_MOVE: begin
				// a move onto the current step leaves a running motion alone
				if (diff != '0) begin
					goal_d    = item.deg;
					dir_neg_d = diff[POS_W];
					left_d    = diff_mag[POS_W-1:0];
					moving_d  = 1'b1;
				end
			end
			FUNC_ZERO: begin
				pos_d     = '0;
				reached_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coil_q    <= '0;
			pos_q     <= '0;
			left_q    <= '0;
			dir_neg_q <= 1'b0;
			moving_q  <= 1'b0;
			goal_q    <= '0;
			reached_q <= '0;
			v_s5      <= 1'b0;
		end else begin
			if (item_ready) v_s5 <= item.valid;
			if (fire) begin
				coil_q    <= coil_d;
				pos_q     <= pos_d;
				left_q    <= left_d;
				dir_neg_q <= dir_neg_d;
				moving_q  <= moving_d;
				goal_q    <= goal_d;
				reached_q <= reached_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			coils_s5  <= coil_d;
			driven_s5 <= driven;
			busy_s5   <= moving_d;
			pos_s5    <= pos_d;
			shown_s5  <= reached_d;
			arr_s5    <= arr;
		end
	end

	assign rsp.valid        = v_s5;
	assign rsp.coils        = coils_s5;
	assign rsp.coils_driven = driven_s5;
	assign rsp.busy_res     = busy_s5;
	assign rsp.step_pos     = pos_s5;
	assign rsp.shown_deg    = shown_s5;
	assign rsp.arrived      = arr_s5;

endmodule

/* src/stepper_absolute_positioner_top.sv */
// Absolute-position full-step stepper driver.
// cmd channel: one transaction per command. func selects tick (0), move (1)
// or zero (2); target_deg, min_deg and max_deg matter for a move only.
// A move clamps the angle to min_deg then max_deg, converts it to a step
// target angle*STEPS_PER_REV/360 and starts a motion toward it. Each tick
// during a motion drives the next coil pattern and moves one step; the tick
// that takes the last step raises arrived. Zero clears position and shown
// angle without stopping a motion.
// rsp channel: exactly one transaction per command, in order, carrying the
// coil levels and the state after that command.
// A result passes the input register, clamp, multiply, reciprocal divide,
// then state update into the result register. Throughput: one command per
// cycle while rsp is not stalled.
// A stalled rsp holds its result; bubbles in the pipeline still fill, and
// cmd.ready drops only once every stage holds a command.
// Reset clears all motion state (coils off, position zero, idle) and empties
// the pipeline at once.
module stepper_absolute_positioner_top #(
	parameter int STEPS_PER_REV = 2048
) (
	input  logic      clk,
	input  logic      arst_n,
	sap_in_if.sink    cmd,
	sap_out_if.source rsp
);
	import sap_pkg::*;

	localparam int QW = quot_width(STEPS_PER_REV);

	item_t         item;
	logic [QW-1:0] quot;
	logic          item_ready;

	sap_conv #(
		.STEPS_PER_REV(STEPS_PER_REV),
		.QW(QW)
	) u_conv (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item(item),
		.quot(quot),
		.item_ready(item_ready)
	);

	sap_core #(
		.QW(QW)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.quot(quot),
		.item_ready(item_ready),
		.rsp(rsp)
	);

endmodule

/* src/sap_chk.sv */
module sap_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [3:0]         rsp_coils,
	input logic               rsp_coils_driven,
	input logic               rsp_busy_res,
	input logic signed [15:0] rsp_step_pos,
	input logic signed [12:0] rsp_shown_deg,
	input logic               rsp_arrived
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coils)
		&& $stable(rsp_coils_driven) && $stable(rsp_busy_res) && $stable(rsp_step_pos)
		&& $stable(rsp_shown_deg) && $stable(rsp_arrived))
		else $error("rsp changed while stalled");

	a_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_arrived |-> rsp_coils_driven && !rsp_busy_res)
		else $error("arrived without a final step");

	a_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_coils_driven |-> rsp_coils == 4'h3 || rsp_coils == 4'h6
		|| rsp_coils == 4'hC || rsp_coils == 4'h9)
		else $error("illegal coil pattern");

	// a step that leaves the motor idle must be the last one
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_coils_driven && !rsp_busy_res |-> rsp_arrived)
		else $error("motion ended without arrived");

endmodule

bind stepper_absolute_positioner_top sap_chk u_sap_chk (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_coils(rsp.coils),
	.rsp_coils_driven(rsp.coils_driven),
	.rsp_busy_res(rsp.busy_res),
	.rsp_step_pos(rsp.step_pos),
	.rsp_shown_deg(rsp.shown_deg),
	.rsp_arrived(rsp.arrived)
);
